@@ hdl/ttu_pkg.sv @@
`timescale 1ns / 1ps

package ttu_pkg;

  // Fixed point and datapath widths
  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;             // coordinate and tangent width
  localparam int DW        = CW + 1;         // corner difference width
  localparam int PW        = 2 * DW;         // product and sum width, signed
  localparam int MAGW      = PW - 1;         // magnitude width of a sum
  localparam int NMW       = MAGW + FRAC_BITS; // scaled numerator magnitude
  localparam int QW        = CW;             // quotient bits developed
  localparam int RIW       = NMW - QW;       // initial partial remainder width
  localparam int QCW       = $clog2(QW);     // divider step counter width

  // Multiply schedule: two products for det and for each numerator
  localparam int MUL_STEPS = 8;
  localparam int MCW       = $clog2(MUL_STEPS + 1);

  // Job queue between front and back, depth a power of two
  localparam int JOB_DEPTH = 2;
  localparam int JPW       = $clog2(JOB_DEPTH);

  // Corner position within the open triangle
  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;

  typedef struct packed {
    logic [CW-1:0] pos_x;
    logic [CW-1:0] pos_y;
    logic [CW-1:0] pos_z;
    logic [CW-1:0] tex_u;
    logic [CW-1:0] tex_v;
  } corner_t;

  typedef struct packed {
    logic [2:0][DW-1:0] dp1;
    logic [2:0][DW-1:0] dp2;
    logic [DW-1:0]      du1;
    logic [DW-1:0]      dv1;
    logic [DW-1:0]      du2;
    logic [DW-1:0]      dv2;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_ITER,
    ST_FIN,
    ST_DONE
  } back_state_e;

endpackage

@@ hdl/ttu_front.sv @@
`timescale 1ns / 1ps

module ttu_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  ttu_pkg::corner_t          corner_i,
  input  ttu_pkg::fifo_stat_t       stat_i,
  output logic                      push_o,
  output ttu_pkg::job_t             job_o
);

  logic [1:0]       cnt_q, cnt_d;
  logic [1:0]       pos;
  logic             accept;
  ttu_pkg::corner_t c0_q, c1_q;

  // Treat the unused counter code as the first corner
  always_comb begin
    pos = (cnt_q == 2'd3) ? ttu_pkg::CORNER_0 : cnt_q;
  end

  // Closing corner waits for room in the job queue
  assign in_ready_o = (pos != ttu_pkg::CORNER_2) || !stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && (pos == ttu_pkg::CORNER_2);

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = (pos == ttu_pkg::CORNER_2) ? ttu_pkg::CORNER_0 : pos + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= ttu_pkg::CORNER_0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold the first two corners of the open triangle
  always_ff @(posedge clk_i) begin
    if (accept && pos == ttu_pkg::CORNER_0) begin
      c0_q <= corner_i;
    end
    if (accept && pos == ttu_pkg::CORNER_1) begin
      c1_q <= corner_i;
    end
  end

  // Edge and texture differences, sign extended by one bit
  always_comb begin
    job_o.dp1[0] = {c1_q.pos_x[ttu_pkg::CW-1], c1_q.pos_x}
                 - {c0_q.pos_x[ttu_pkg::CW-1], c0_q.pos_x};
    job_o.dp1[1] = {c1_q.pos_y[ttu_pkg::CW-1], c1_q.pos_y}
                 - {c0_q.pos_y[ttu_pkg::CW-1], c0_q.pos_y};
    job_o.dp1[2] = {c1_q.pos_z[ttu_pkg::CW-1], c1_q.pos_z}
                 - {c0_q.pos_z[ttu_pkg::CW-1], c0_q.pos_z};
    job_o.dp2[0] = {corner_i.pos_x[ttu_pkg::CW-1], corner_i.pos_x}
                 - {c0_q.pos_x[ttu_pkg::CW-1], c0_q.pos_x};
    job_o.dp2[1] = {corner_i.pos_y[ttu_pkg::CW-1], corner_i.pos_y}
                 - {c0_q.pos_y[ttu_pkg::CW-1], c0_q.pos_y};
    job_o.dp2[2] = {corner_i.pos_z[ttu_pkg::CW-1], corner_i.pos_z}
                 - {c0_q.pos_z[ttu_pkg::CW-1], c0_q.pos_z};
    job_o.du1    = {c1_q.tex_u[ttu_pkg::CW-1], c1_q.tex_u}
                 - {c0_q.tex_u[ttu_pkg::CW-1], c0_q.tex_u};
    job_o.dv1    = {c1_q.tex_v[ttu_pkg::CW-1], c1_q.tex_v}
                 - {c0_q.tex_v[ttu_pkg::CW-1], c0_q.tex_v};
    job_o.du2    = {corner_i.tex_u[ttu_pkg::CW-1], corner_i.tex_u}
                 - {c0_q.tex_u[ttu_pkg::CW-1], c0_q.tex_u};
    job_o.dv2    = {corner_i.tex_v[ttu_pkg::CW-1], corner_i.tex_v}
                 - {c0_q.tex_v[ttu_pkg::CW-1], c0_q.tex_v};
  end

endmodule

@@ hdl/ttu_job_fifo.sv @@
`timescale 1ns / 1ps

module ttu_job_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ttu_pkg::job_t       push_data_i,
  input  logic                pop_i,
  output ttu_pkg::job_t       pop_data_o,
  output ttu_pkg::fifo_stat_t stat_o
);

  ttu_pkg::job_t          mem_q [ttu_pkg::JOB_DEPTH];
  logic [ttu_pkg::JPW-1:0] wr_ptr_q, wr_ptr_d;
  logic [ttu_pkg::JPW-1:0] rd_ptr_q, rd_ptr_d;
  logic [ttu_pkg::JPW:0]   fill_q, fill_d;
  logic                    do_push, do_pop;

  assign stat_o.full  = (fill_q == (ttu_pkg::JPW + 1)'(ttu_pkg::JOB_DEPTH));
  assign stat_o.empty = (fill_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == ttu_pkg::JPW'(ttu_pkg::JOB_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == ttu_pkg::JPW'(ttu_pkg::JOB_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hdl/ttu_back.sv @@
`timescale 1ns / 1ps

module ttu_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ttu_pkg::fifo_stat_t        stat_i,
  output logic                       pop_o,
  input  ttu_pkg::job_t              job_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ttu_pkg::CW-1:0]     tangent_x_o,
  output logic [ttu_pkg::CW-1:0]     tangent_y_o,
  output logic [ttu_pkg::CW-1:0]     tangent_z_o,
  output logic                       degenerate_o,
  output logic                       clipped_o
);

  localparam int CW   = ttu_pkg::CW;
  localparam int DW   = ttu_pkg::DW;
  localparam int PW   = ttu_pkg::PW;
  localparam int MAGW = ttu_pkg::MAGW;
  localparam int NMW  = ttu_pkg::NMW;
  localparam int QW   = ttu_pkg::QW;
  localparam int RIW  = ttu_pkg::RIW;
  localparam int QCW  = ttu_pkg::QCW;
  localparam int MCW  = ttu_pkg::MCW;

  localparam logic [CW-1:0] SAT_MAX  = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] SAT_MIN  = {1'b1, {(CW-1){1'b0}}};
  localparam logic [QW-1:0] NEG_LIM  = {1'b1, {(QW-1){1'b0}}};

  ttu_pkg::back_state_e state_q, state_d;
  logic [MCW-1:0]       cnt_q, cnt_d;
  logic [1:0]           comp_q, comp_d;
  logic [QCW-1:0]       step_q, step_d;

  ttu_pkg::job_t        job_q, job_d;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [PW-1:0] acc_q [4];
  logic signed [PW-1:0] acc_d [4];
  logic [MAGW-1:0]      dmag_q, dmag_d;
  logic [MAGW-1:0]      rem_q, rem_d;
  logic [QW-1:0]        quo_q, quo_d;
  logic                 neg_q, neg_d;
  logic                 ovf_q, ovf_d;
  logic [CW-1:0]        tan_q [3];
  logic [CW-1:0]        tan_d [3];
  logic                 degen_q, degen_d;
  logic                 clip_q, clip_d;

  // Multiply operands and accumulate slot
  logic [1:0]           mul_sel, acc_sel;
  logic [MCW-1:0]       acc_step;
  logic signed [DW-1:0] op_a, op_b;

  // Divider setup and step terms
  logic signed [PW-1:0] num, det, nabs, dabs;
  logic [NMW-1:0]       nmag;
  logic [MAGW-1:0]      rinit;
  logic [MAGW:0]        rshift, rdiff;
  logic                 ge, big, clip_now;
  logic [CW-1:0]        sat_val;

  assign mul_sel  = cnt_q[2:1];
  assign acc_step = cnt_q - 1'b1;
  assign acc_sel  = acc_step[2:1];

  // Select the multiplier operands for this step
  always_comb begin
    unique case (mul_sel)
      2'd0: begin
        op_a = cnt_q[0] ? job_q.dv1 : job_q.du1;
        op_b = cnt_q[0] ? job_q.du2 : job_q.dv2;
      end
      2'd1: begin
        op_a = cnt_q[0] ? job_q.dp2[0] : job_q.dp1[0];
        op_b = cnt_q[0] ? job_q.dv1 : job_q.dv2;
      end
      2'd2: begin
        op_a = cnt_q[0] ? job_q.dp2[1] : job_q.dp1[1];
        op_b = cnt_q[0] ? job_q.dv1 : job_q.dv2;
      end
      default: begin
        op_a = cnt_q[0] ? job_q.dp2[2] : job_q.dp1[2];
        op_b = cnt_q[0] ? job_q.dv1 : job_q.dv2;
      end
    endcase
  end

  // Divider setup: magnitudes and the leading partial remainder
  always_comb begin
    num   = acc_q[comp_q + 2'd1];
    det   = acc_q[0];
    nabs  = num[PW-1] ? -num : num;
    dabs  = det[PW-1] ? -det : det;
    nmag  = {nabs[MAGW-1:0], {ttu_pkg::FRAC_BITS{1'b0}}};
    rinit = {{(MAGW-RIW){1'b0}}, nmag[NMW-1:QW]};
  end

  // One restoring step per cycle
  always_comb begin
    rshift = {rem_q, quo_q[QW-1]};
    rdiff  = rshift - {1'b0, dmag_q};
    ge     = rshift >= {1'b0, dmag_q};
  end

  // Saturate the finished quotient
  always_comb begin
    big      = neg_q ? (quo_q > NEG_LIM) : quo_q[QW-1];
    clip_now = ovf_q || big;
    if (clip_now) begin
      sat_val = neg_q ? SAT_MIN : SAT_MAX;
    end else begin
      sat_val = neg_q ? CW'(-quo_q) : CW'(quo_q);
    end
  end

  // Next state and datapath updates
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    step_d  = step_q;
    job_d   = job_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    dmag_d  = dmag_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    neg_d   = neg_q;
    ovf_d   = ovf_q;
    tan_d   = tan_q;
    degen_d = degen_q;
    clip_d  = clip_q;
    pop_o   = 1'b0;
    out_valid_o = 1'b0;

    unique case (state_q)
      ttu_pkg::ST_IDLE: begin
        if (!stat_i.empty) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          cnt_d   = '0;
          comp_d  = 2'd0;
          degen_d = 1'b0;
          clip_d  = 1'b0;
          tan_d   = '{default: '0};
          state_d = ttu_pkg::ST_MUL;
        end
      end
      ttu_pkg::ST_MUL: begin
        if (cnt_q < MCW'(ttu_pkg::MUL_STEPS)) begin
          prod_d = op_a * op_b;
        end
        if (cnt_q != '0) begin
          acc_d[acc_sel] = acc_step[0] ? acc_q[acc_sel] - prod_q : prod_q;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == MCW'(ttu_pkg::MUL_STEPS)) begin
          if (acc_q[0] == '0) begin
            degen_d = 1'b1;
            state_d = ttu_pkg::ST_DONE;
          end else begin
            state_d = ttu_pkg::ST_PREP;
          end
        end
      end
      ttu_pkg::ST_PREP: begin
        dmag_d  = dabs[MAGW-1:0];
        rem_d   = rinit;
        quo_d   = nmag[QW-1:0];
        neg_d   = num[PW-1] ^ det[PW-1];
        ovf_d   = rinit >= dabs[MAGW-1:0];
        step_d  = '0;
        state_d = (rinit >= dabs[MAGW-1:0]) ? ttu_pkg::ST_FIN : ttu_pkg::ST_ITER;
      end
      ttu_pkg::ST_ITER: begin
        rem_d  = ge ? rdiff[MAGW-1:0] : rshift[MAGW-1:0];
        quo_d  = {quo_q[QW-2:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == QCW'(QW - 1)) begin
          state_d = ttu_pkg::ST_FIN;
        end
      end
      ttu_pkg::ST_FIN: begin
        tan_d[comp_q] = sat_val;
        clip_d        = clip_q || clip_now;
        if (comp_q == 2'd2) begin
          state_d = ttu_pkg::ST_DONE;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ttu_pkg::ST_PREP;
        end
      end
      ttu_pkg::ST_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ttu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ttu_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttu_pkg::ST_IDLE;
      cnt_q   <= '0;
      comp_q  <= 2'd0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      comp_q  <= comp_d;
      step_q  <= step_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    dmag_q  <= dmag_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    neg_q   <= neg_d;
    ovf_q   <= ovf_d;
    tan_q   <= tan_d;
    degen_q <= degen_d;
    clip_q  <= clip_d;
  end

  assign tangent_x_o  = tan_q[0];
  assign tangent_y_o  = tan_q[1];
  assign tangent_z_o  = tan_q[2];
  assign degenerate_o = degen_q;
  assign clipped_o    = clip_q;

endmodule

@@ hdl/triangle_tangent_unit.sv @@
`timescale 1ns / 1ps

// Per-triangle tangent from texture coordinates. Corners stream in one beat
// each; every third corner closes a triangle and yields one result beat with
// the tangent (dp1*dv2 - dp2*dv1) * 2^16 / det in Q16.16, truncated toward
// zero and saturated, where det = du1*dv2 - dv1*du2. A zero det gives a zero
// tangent with degenerate set. The front takes corners at one beat per cycle
// but holds the closing corner while the queue is full, and hands each closed
// triangle to a two-entry job queue. The back works one triangle at a time:
// it loads the job, forms eight products on one 33x33 multiplier, then three
// quotients from a one-bit-per-cycle restoring divider, and shows the result
// beat; a degenerate one skips the divider. The divider sets the sustained
// rate; a waiting result does not stop the front until the queue is full.

module triangle_tangent_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [159:0] s_axis_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,   // tangent_x, tangent_y, tangent_z
  output logic [1:0]   m_axis_tuser    // degenerate, clipped
);

  ttu_pkg::corner_t    corner;
  ttu_pkg::job_t       push_job, pop_job;
  ttu_pkg::fifo_stat_t stat;
  logic                push, pop;

  // Unpack the input beat
  assign corner.pos_x = s_axis_tdata[31:0];
  assign corner.pos_y = s_axis_tdata[63:32];
  assign corner.pos_z = s_axis_tdata[95:64];
  assign corner.tex_u = s_axis_tdata[127:96];
  assign corner.tex_v = s_axis_tdata[159:128];

  ttu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .corner_i   (corner),
    .stat_i     (stat),
    .push_o     (push),
    .job_o      (push_job)
  );

  ttu_job_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .stat_o      (stat)
  );

  ttu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stat_i       (stat),
    .pop_o        (pop),
    .job_i        (pop_job),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .tangent_x_o  (m_axis_tdata[31:0]),
    .tangent_y_o  (m_axis_tdata[63:32]),
    .tangent_z_o  (m_axis_tdata[95:64]),
    .degenerate_o (m_axis_tuser[0]),
    .clipped_o    (m_axis_tuser[1])
  );

endmodule

@@ tb/tangent_checker.sv @@
`timescale 1ns / 1ps

// Watches both stream channels of the tangent unit, keeps its own copy of the
// open triangle, works out the tangent of every closed triangle and compares
// each result beat against the oldest tangent still owed.
module tangent_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         corner_valid_i,
  input  logic         corner_ready_i,
  input  logic [159:0] corner_data_i,    // pos_x, pos_y, pos_z, tex_u, tex_v
  input  logic         tangent_valid_i,
  input  logic         tangent_ready_i,
  input  logic [95:0]  tangent_data_i,   // tangent_x, tangent_y, tangent_z
  input  logic [1:0]   tangent_flags_i,  // degenerate, clipped
  output int unsigned  fail_count_o,
  output int unsigned  due_count_o
);

  typedef struct packed {
    logic [31:0] tangent_x;
    logic [31:0] tangent_y;
    logic [31:0] tangent_z;
    logic        degenerate;
    logic        clipped;
  } tangent_t;

  // Corners 0 and 1 of the open triangle
  logic signed [31:0] kept_pos [6];
  logic signed [31:0] kept_tex [4];
  logic [1:0]         corners_held;

  tangent_t    tangents_owed_q [$];
  int unsigned mismatches;

  assign fail_count_o = mismatches;

  // Tangent of the open triangle closed by the given corner
  function automatic tangent_t predict_tangent(input logic [159:0] beat);
    logic signed [31:0] far_pos [3];
    logic signed [32:0] du1, dv1, du2, dv2, dp1, dp2;
    logic signed [67:0] det, num;
    logic [67:0]        det_mag, num_mag;
    logic [127:0]       quot;
    logic [31:0]        cap;
    logic [31:0]        comp [3];
    logic               neg;
    tangent_t           res;
    int                 i;
    far_pos[0] = beat[31:0];
    far_pos[1] = beat[63:32];
    far_pos[2] = beat[95:64];
    du1 = kept_tex[2] - kept_tex[0];
    dv1 = kept_tex[3] - kept_tex[1];
    du2 = $signed(beat[127:96]) - kept_tex[0];
    dv2 = $signed(beat[159:128]) - kept_tex[1];
    det = du1 * dv2 - dv1 * du2;
    res = '0;
    if (det == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    det_mag = det[67] ? -det : det;
    for (i = 0; i < 3; i++) begin
      dp1 = kept_pos[3 + i] - kept_pos[i];
      dp2 = far_pos[i] - kept_pos[i];
      num = dp1 * dv2 - dp2 * dv1;
      num_mag = num[67] ? -num : num;
      neg = num[67] ^ det[67];
      // Divide magnitudes exactly, truncating toward zero
      quot = {60'd0, num_mag} << ttu_pkg::FRAC_BITS;
      quot = quot / {60'd0, det_mag};
      cap = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      if (quot > {96'd0, cap}) begin
        quot = {96'd0, cap};
        res.clipped = 1'b1;
      end
      comp[i] = neg ? -quot[31:0] : quot[31:0];
    end
    res.tangent_x = comp[0];
    res.tangent_y = comp[1];
    res.tangent_z = comp[2];
    return res;
  endfunction

  task automatic check_field(input string label, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, label, want, got);
      mismatches++;
    end
  endtask

  // Compare result beats first, then take in the corner beat
  always @(posedge clk_i or negedge rst_ni) begin
    tangent_t owed;
    if (!rst_ni) begin
      corners_held = ttu_pkg::CORNER_0;
      tangents_owed_q.delete();
      mismatches = 0;
      due_count_o <= 0;
    end else begin
      if (tangent_valid_i && tangent_ready_i) begin
        if (tangents_owed_q.size() == 0) begin
          $display("%0t: tangent beat with no triangle closed, data %h flags %b",
                   $time, tangent_data_i, tangent_flags_i);
          mismatches++;
        end else begin
          owed = tangents_owed_q.pop_front();
          check_field("tangent_x", owed.tangent_x, tangent_data_i[31:0]);
          check_field("tangent_y", owed.tangent_y, tangent_data_i[63:32]);
          check_field("tangent_z", owed.tangent_z, tangent_data_i[95:64]);
          check_field("degenerate", 32'(owed.degenerate), 32'(tangent_flags_i[0]));
          check_field("clipped", 32'(owed.clipped), 32'(tangent_flags_i[1]));
        end
      end
      if (corner_valid_i && corner_ready_i) begin
        if (corners_held == ttu_pkg::CORNER_2) begin
          tangents_owed_q.insert(tangents_owed_q.size(), predict_tangent(corner_data_i));
          corners_held = ttu_pkg::CORNER_0;
        end else begin
          kept_pos[3'(corners_held * 3)]     = corner_data_i[31:0];
          kept_pos[3'(corners_held * 3 + 1)] = corner_data_i[63:32];
          kept_pos[3'(corners_held * 3 + 2)] = corner_data_i[95:64];
          kept_tex[2'(corners_held * 2)]     = corner_data_i[127:96];
          kept_tex[2'(corners_held * 2 + 1)] = corner_data_i[159:128];
          corners_held = corners_held + 2'd1;
        end
      end
      due_count_o <= tangents_owed_q.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam logic [31:0] ONE   = 32'h0001_0000;
  localparam logic [31:0] S_MIN = 32'h8000_0000;
  localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
  localparam int QUIET_LIMIT    = 4000;
  localparam int TAIL_CYCLES    = 200;
  localparam int TRIS_PER_PHASE = 56;

  // Triangle flavors for the random part
  localparam int TRI_MODEST  = 0;
  localparam int TRI_FULL    = 1;
  localparam int TRI_THIN_UV = 2;
  localparam int TRI_FLAT_UV = 3;
  localparam int TRI_EDGES   = 4;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata = '0;   // pos_x, pos_y, pos_z, tex_u, tex_v
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [95:0]  m_axis_tdata;        // tangent_x, tangent_y, tangent_z
  logic [1:0]   m_axis_tuser;        // degenerate, clipped

  int unsigned fail_count;
  int unsigned tangents_due;
  int          src_idle;
  int          sink_idle;
  int          quiet_cycles;

  triangle_tangent_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  tangent_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .corner_valid_i  (s_axis_tvalid),
    .corner_ready_i  (s_axis_tready),
    .corner_data_i   (s_axis_tdata),
    .tangent_valid_i (m_axis_tvalid),
    .tangent_ready_i (m_axis_tready),
    .tangent_data_i  (m_axis_tdata),
    .tangent_flags_i (m_axis_tuser),
    .fail_count_o    (fail_count),
    .due_count_o     (tangents_due)
  );

  always #5 clk_i = ~clk_i;

  // Stall the result channel at random
  always @(posedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= sink_idle);
  end

  // End the run when no beat moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [159:0] corner(input logic [31:0] x, y, z, u, v);
    return {v, u, z, y, x};
  endfunction

  function automatic logic [31:0] spread(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [31:0] edge_value();
    case ($urandom_range(0, 4))
      0: return S_MIN;
      1: return S_MAX;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Present one corner beat, idling first at random, and hold until taken
  task automatic send_corner(input logic [159:0] beat);
    while ($urandom_range(0, 99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold off the sender until every owed tangent has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (tangents_due != 0);
  endtask

  task automatic send_random_triangle(input int flavor);
    logic [31:0] pos [3][3];
    logic [31:0] tex_u [3];
    logic [31:0] tex_v [3];
    logic [31:0] step_u, step_v;
    int          k, n, j;
    for (k = 0; k < 3; k++) begin
      for (j = 0; j < 3; j++) begin
        case (flavor)
          TRI_MODEST, TRI_FLAT_UV: pos[k][j] = spread(32'h0010_0000);
          TRI_EDGES:               pos[k][j] = edge_value();
          default:                 pos[k][j] = $urandom();
        endcase
      end
    end
    case (flavor)
      TRI_MODEST: begin
        for (k = 0; k < 3; k++) begin
          tex_u[k] = spread(32'h0004_0000);
          tex_v[k] = spread(32'h0004_0000);
        end
      end
      TRI_THIN_UV: begin
        tex_u[0] = $urandom();
        tex_v[0] = $urandom();
        for (k = 1; k < 3; k++) begin
          tex_u[k] = tex_u[0] + spread(4);
          tex_v[k] = tex_v[0] + spread(4);
        end
      end
      TRI_FLAT_UV: begin
        // Keep all three texture points on one line
        tex_u[0] = spread(32'h0100_0000);
        tex_v[0] = spread(32'h0100_0000);
        step_u   = spread(32'h0000_1000);
        step_v   = spread(32'h0000_1000);
        for (k = 1; k < 3; k++) begin
          n = int'($urandom_range(0, 16)) - 8;
          tex_u[k] = tex_u[0] + n * step_u;
          tex_v[k] = tex_v[0] + n * step_v;
        end
      end
      TRI_EDGES: begin
        for (k = 0; k < 3; k++) begin
          tex_u[k] = edge_value();
          tex_v[k] = edge_value();
        end
      end
      default: begin
        for (k = 0; k < 3; k++) begin
          tex_u[k] = $urandom();
          tex_v[k] = $urandom();
        end
      end
    endcase
    for (k = 0; k < 3; k++) begin
      send_corner(corner(pos[k][0], pos[k][1], pos[k][2], tex_u[k], tex_v[k]));
    end
  endtask

  task automatic send_random_phase(input int src_pct, input int sink_pct);
    int t, r;
    src_idle  = src_pct;
    sink_idle = sink_pct;
    for (t = 0; t < TRIS_PER_PHASE; t++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      send_random_triangle(TRI_MODEST);
      else if (r < 65) send_random_triangle(TRI_FULL);
      else if (r < 80) send_random_triangle(TRI_THIN_UV);
      else if (r < 93) send_random_triangle(TRI_FLAT_UV);
      else             send_random_triangle(TRI_EDGES);
    end
    drain();
  endtask

  initial begin
    src_idle  = 31;
    sink_idle = 54;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All zero: degenerate
    repeat (3) send_corner(corner(0, 0, 0, 0, 0));
    // Unit triangle: tangent along x
    send_corner(corner(0, 0, 0, 0, 0));
    send_corner(corner(ONE, 0, 0, ONE, 0));
    send_corner(corner(0, ONE, 0, 0, ONE));
    // Tangent equal to dp1: most negative exact, positive just past the top
    send_corner(corner(0, S_MIN, 0, 0, 0));
    send_corner(corner(S_MIN, 0, S_MAX, ONE, 0));
    send_corner(corner(0, 0, 0, 0, ONE));
    // Smallest nonzero det with widest position spread
    send_corner(corner(S_MIN, S_MAX, 0, 0, 0));
    send_corner(corner(S_MAX, S_MIN, 1, 1, 0));
    send_corner(corner(0, 0, 0, 0, 1));
    // Widest texture spread: largest det
    send_corner(corner(0, 0, 0, S_MIN, S_MIN));
    send_corner(corner(ONE, 2 * ONE, -ONE, S_MAX, S_MIN));
    send_corner(corner(S_MAX, S_MIN, 7, S_MIN, S_MAX));
    // Positive det from negative texture differences, with mixed signs
    send_corner(corner(0, 0, 0, ONE, ONE));
    send_corner(corner(3 * ONE, -2 * ONE, ONE / 2, 0, ONE));
    send_corner(corner(-ONE, ONE, 5, ONE, -ONE));
    // Collinear texture points: degenerate despite spread positions
    send_corner(corner(ONE, -ONE, S_MAX, 0, 0));
    send_corner(corner(S_MIN, 4 * ONE, 0, ONE, 2 * ONE));
    send_corner(corner(7, S_MAX, -3, 3 * ONE, 6 * ONE));
    // All ones corner and a det of one from negative texture points
    send_corner(corner(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_corner(corner(S_MAX, 0, S_MIN, 0, 32'hFFFF_FFFF));
    send_corner(corner(0, S_MIN, S_MAX, 32'hFFFF_FFFF, 0));
    drain();

    send_random_phase(31, 54);
    send_random_phase(54, 31);
    send_random_phase(0, 0);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && tangents_due == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ttu_pkg.sv
hdl/ttu_front.sv
hdl/ttu_job_fifo.sv
hdl/ttu_back.sv
hdl/triangle_tangent_unit.sv
tb/tangent_checker.sv
tb/testbench.sv
